// ===== rtl/core/dma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dma_pkg;

  // Default window shape.
  localparam int DEF_WINDOW_DEPTH = 8;
  localparam int DEF_SAMPLE_BITS  = 16;

  // Threshold registers: four per channel, fine channel first.
  localparam int NUM_LIMITS     = 4;
  localparam int LIMIT_BITS     = 16;
  localparam int LIM_IDX_BITS   = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = LIMIT_BITS;
  localparam int LEVEL_BITS     = 3;

  // Register index map.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FINE_BASE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_BASE = 3'd4;

  typedef logic [NUM_LIMITS-1:0][LIMIT_BITS-1:0] limit_set_t;

  // Threshold reset values, entry 0 is the level 1 limit.
  localparam limit_set_t FINE_LIMIT_RST   = {16'd1000, 16'd500, 16'd200, 16'd100};
  localparam limit_set_t COARSE_LIMIT_RST = {16'd3000, 16'd2000, 16'd500, 16'd300};

endpackage

`default_nettype wire

// ===== rtl/core/dma_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module dma_div #(
  parameter int DIVIDEND_BITS = 19,
  parameter int DIVISOR_BITS  = 4
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [DIVIDEND_BITS-1:0]  dividend,
  input  wire [DIVISOR_BITS-1:0]   divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     busy_r;
  logic                     done_r;
  logic [STEP_BITS-1:0]     step_r;
  logic [DIVISOR_BITS-1:0]  rem_r;
  logic [DIVISOR_BITS-1:0]  dvs_r;
  logic [DIVIDEND_BITS-1:0] quo_r;

  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;
  logic [DIVISOR_BITS-1:0]  rem_nxt;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_BITS-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_BITS'(DIVIDEND_BITS);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVIDEND_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  // A finished division never overlaps a running one.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

`default_nettype wire

// ===== rtl/core/dual_moving_average_level.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted item sweeps the held samples out of the rings, then the shared restoring
//   divider forms the fine mean and then the coarse mean; the result loads once the output is free.
// in_stall is high outside idle, so a new item is taken only once the last one is through;
//   the sweep reads one ring entry per cycle and the single divider serves both channels.
// Reset: synchronous, active low; clears the window, the write slot and the held count, and
//   loads the threshold registers with their default limits. Ring contents are not cleared.

module dual_moving_average_level #(
  parameter int WINDOW_DEPTH = dma_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = dma_pkg::DEF_SAMPLE_BITS
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // Configuration port
  input  wire                                     cfg_we,
  input  wire [dma_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  wire [dma_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
  // Input channel
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire [SAMPLE_BITS-1:0]                   in_fine_sample,
  input  wire [SAMPLE_BITS-1:0]                   in_coarse_sample,
  // Result channel
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic [SAMPLE_BITS-1:0]                  out_fine_average,
  output logic [SAMPLE_BITS-1:0]                  out_coarse_average,
  output logic [dma_pkg::LEVEL_BITS-1:0]          out_fine_level,
  output logic [dma_pkg::LEVEL_BITS-1:0]          out_coarse_level,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]       out_window_filled
);

  import dma_pkg::*;

  localparam int IDX_BITS = $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS = SAMPLE_BITS + IDX_BITS;
  localparam int CMP_BITS = (SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DRAIN,
    S_START_F,
    S_WAIT_F,
    S_START_C,
    S_WAIT_C,
    S_FINISH
  } state_t;

  state_t                  state_r;
  logic [IDX_BITS-1:0]     slot_r;
  logic [CNT_BITS-1:0]     count_r;
  logic [IDX_BITS-1:0]     rd_addr_r;
  logic                    rd_vld_r;
  logic [SAMPLE_BITS-1:0]  rd_fine_r;
  logic [SAMPLE_BITS-1:0]  rd_coarse_r;
  logic [SUM_BITS-1:0]     fine_sum_r;
  logic [SUM_BITS-1:0]     coarse_sum_r;
  logic [SUM_BITS-1:0]     fine_q_r;
  logic [SUM_BITS-1:0]     coarse_q_r;
  limit_set_t              fine_lim_r;
  limit_set_t              coarse_lim_r;

  logic                    out_valid_r;
  logic [SAMPLE_BITS-1:0]  out_fine_r;
  logic [SAMPLE_BITS-1:0]  out_coarse_r;
  logic [LEVEL_BITS-1:0]   out_fine_lvl_r;
  logic [LEVEL_BITS-1:0]   out_coarse_lvl_r;
  logic [CNT_BITS-1:0]     out_filled_r;

  logic [SAMPLE_BITS-1:0]  fine_mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0]  coarse_mem [WINDOW_DEPTH];

  logic                    in_acc;
  logic                    out_free;
  logic                    last_issue;
  logic                    div_start;
  logic [SUM_BITS-1:0]     div_dividend;
  logic                    div_done;
  logic [SUM_BITS-1:0]     div_quotient;
  logic [CFG_INDEX_BITS-1:0] cfg_off;

  // Highest level whose limit the mean strictly exceeds.
  function automatic logic [LEVEL_BITS-1:0] level_of(input logic [CMP_BITS-1:0] mean,
                                                     input limit_set_t lim);
    logic [LEVEL_BITS-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < NUM_LIMITS; i++) begin
      if (mean > CMP_BITS'(lim[i])) lvl = LEVEL_BITS'(i + 1);
    end
    return lvl;
  endfunction

  // Handshake decode.
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign last_issue = (CNT_BITS'(rd_addr_r) == count_r - 1'b1);

  // The shared divider handles the fine sum first, then the coarse sum.
  assign div_start    = (state_r == S_START_F) || (state_r == S_START_C);
  assign div_dividend = (state_r == S_START_C) ? coarse_sum_r : fine_sum_r;

  dma_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (CNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sample rings: written on accept, read one entry per cycle during the sweep.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fine_mem[slot_r]   <= in_fine_sample;
      coarse_mem[slot_r] <= in_coarse_sample;
    end
    rd_fine_r   <= fine_mem[rd_addr_r];
    rd_coarse_r <= coarse_mem[rd_addr_r];
  end

  // Threshold registers.
  assign cfg_off = cfg_index - REG_COARSE_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_lim_r   <= FINE_LIMIT_RST;
      coarse_lim_r <= COARSE_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index < REG_COARSE_BASE) begin
        fine_lim_r[cfg_index[LIM_IDX_BITS-1:0] - REG_FINE_BASE[LIM_IDX_BITS-1:0]] <= cfg_wdata;
      end else if (cfg_off < CFG_INDEX_BITS'(NUM_LIMITS)) begin
        coarse_lim_r[cfg_off[LIM_IDX_BITS-1:0]] <= cfg_wdata;
      end
    end
  end

  // Sequencer with window state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      count_r     <= '0;
      rd_addr_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_SUM);
      // In the finish state the output register is reloaded below instead.
      if (out_valid_r && !out_stall && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      if (rd_vld_r) begin
        fine_sum_r   <= fine_sum_r + SUM_BITS'(rd_fine_r);
        coarse_sum_r <= coarse_sum_r + SUM_BITS'(rd_coarse_r);
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            slot_r       <= (slot_r == IDX_BITS'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
            if (count_r != CNT_BITS'(WINDOW_DEPTH)) count_r <= count_r + 1'b1;
            rd_addr_r    <= '0;
            fine_sum_r   <= '0;
            coarse_sum_r <= '0;
            state_r      <= S_SUM;
          end
        end
        S_SUM: begin
          if (last_issue) begin
            state_r <= S_DRAIN;
          end else begin
            rd_addr_r <= rd_addr_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_START_F;
        end
        S_START_F: begin
          state_r <= S_WAIT_F;
        end
        S_WAIT_F: begin
          if (div_done) begin
            fine_q_r <= div_quotient;
            state_r  <= S_START_C;
          end
        end
        S_START_C: begin
          state_r <= S_WAIT_C;
        end
        S_WAIT_C: begin
          if (div_done) begin
            coarse_q_r <= div_quotient;
            state_r    <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Load the result once the output register is free or being emptied.
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_fine_r       <= fine_q_r[SAMPLE_BITS-1:0];
            out_coarse_r     <= coarse_q_r[SAMPLE_BITS-1:0];
            out_fine_lvl_r   <= level_of(CMP_BITS'(fine_q_r), fine_lim_r);
            out_coarse_lvl_r <= level_of(CMP_BITS'(coarse_q_r), coarse_lim_r);
            out_filled_r     <= count_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fine_average   = out_fine_r;
  assign out_coarse_average = out_coarse_r;
  assign out_fine_level     = out_fine_lvl_r;
  assign out_coarse_level   = out_coarse_lvl_r;
  assign out_window_filled  = out_filled_r;

  // The held count never passes the window depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(WINDOW_DEPTH))
    else $error("held count beyond window depth");

  // An accepted item always starts a ring sweep.
  a_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SUM) && (rd_addr_r == '0))
    else $error("accepted item did not start a sweep");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_WAIT_F) || (state_r == S_WAIT_C))
    else $error("divider finished outside a wait state");

  // A new result appears only when the sequencer finishes an item.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result raised outside finish");

endmodule

`default_nettype wire
